// ===== rtl/core/gcdl_pkg.sv =====
// ----------------------------------------------------------------------------
// GCD/LCM unit package
// Command codes shared by the sequencer and the stream interface.
// ----------------------------------------------------------------------------
package gcdl_pkg;

    typedef logic t_cmd;

    localparam t_cmd CMD_GCD = 1'b0;
    localparam t_cmd CMD_LCM = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_status;

endpackage

// ===== rtl/core/gcdl_bgcd.sv =====
// ----------------------------------------------------------------------------
// Binary GCD engine
// Reduces two magnitudes by shifts and one shared subtractor, then restores
// the common power of two one bit per cycle.
// ----------------------------------------------------------------------------
module gcdl_bgcd #(
    parameter int W = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [W-1:0]          i_a,
    input  logic [W-1:0]          i_b,
    output gcdl_pkg::t_unit_status o_status,
    output logic [W-1:0]          o_gcd
);

    localparam int KW = $clog2(W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_RESTORE
    } t_state;

    t_state        r_state;
    logic          r_done;
    logic [W-1:0]  r_x;
    logic [W-1:0]  r_y;
    logic [W-1:0]  r_g;
    logic [KW-1:0] r_k;
    logic          x_ge_y;
    logic [W-1:0]  diff;

    always_comb begin
        x_ge_y = (r_x >= r_y);
        diff   = x_ge_y ? (r_x - r_y) : (r_y - r_x);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_x     <= i_a;
                        r_y     <= i_b;
                        r_k     <= '0;
                        r_state <= ST_REDUCE;
                    end
                end
                ST_REDUCE: begin
                    if ((r_x == '0) || (r_y == '0)) begin
                        r_g     <= r_x | r_y;
                        r_state <= ST_RESTORE;
                    end else if (!r_x[0] && !r_y[0]) begin
                        r_x <= r_x >> 1;
                        r_y <= r_y >> 1;
                        r_k <= r_k + KW'(1);
                    end else if (!r_x[0]) begin
                        r_x <= r_x >> 1;
                    end else if (!r_y[0]) begin
                        r_y <= r_y >> 1;
                    end else if (x_ge_y) begin
                        r_x <= diff >> 1;
                    end else begin
                        r_y <= diff >> 1;
                    end
                end
                ST_RESTORE: begin
                    if (r_k == '0) begin
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_g <= r_g << 1;
                        r_k <= r_k - KW'(1);
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_status.busy = (r_state != ST_IDLE);
    assign o_status.done = r_done;
    assign o_gcd         = r_g;

endmodule

// ===== rtl/core/gcdl_div.sv =====
// ----------------------------------------------------------------------------
// Restoring divider
// Produces one quotient bit per cycle with a single compare and subtract.
// ----------------------------------------------------------------------------
module gcdl_div #(
    parameter int W = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [W-1:0]          i_dividend,
    input  logic [W-1:0]          i_divisor,
    output gcdl_pkg::t_unit_status o_status,
    output logic [W-1:0]          o_quotient
);

    localparam int CW = $clog2(W);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W:0]    r_rem;
    logic [W-1:0]  r_num;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_den;
    logic [W:0]    trial;
    logic          fits;

    always_comb begin
        trial = {r_rem[W-1:0], r_num[W-1]};
        fits  = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_start) begin
                    r_rem  <= '0;
                    r_num  <= i_dividend;
                    r_den  <= i_divisor;
                    r_quo  <= '0;
                    r_cnt  <= CW'(W - 1);
                    r_busy <= 1'b1;
                end
            end else begin
                r_rem <= fits ? (trial - {1'b0, r_den}) : trial;
                r_num <= r_num << 1;
                r_quo <= {r_quo[W-2:0], fits};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CW'(1);
                end
            end
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_quo;

endmodule

// ===== rtl/core/gcdl_mul.sv =====
// ----------------------------------------------------------------------------
// Saturating shift-add multiplier
// Accumulates one multiplier bit per cycle, most significant first, and
// stops growing once the running product passes the saturation limit.
// ----------------------------------------------------------------------------
module gcdl_mul #(
    parameter int W = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [W-1:0]          i_mplier,
    input  logic [W-1:0]          i_mcand,
    output gcdl_pkg::t_unit_status o_status,
    output logic [W-2:0]          o_product,
    output logic                  o_overflow
);

    localparam int CW = $clog2(W);
    localparam logic [W+1:0] LIMIT = {3'b000, {(W-1){1'b1}}};

    logic          r_busy;
    logic          r_done;
    logic          r_ovf;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_q;
    logic [W-1:0]  r_m;
    logic [W:0]    r_acc;
    logic [W+1:0]  sum;

    always_comb begin
        sum = {r_acc, 1'b0} + (r_q[W-1] ? {2'b00, r_m} : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_start) begin
                    r_q    <= i_mplier;
                    r_m    <= i_mcand;
                    r_acc  <= '0;
                    r_ovf  <= 1'b0;
                    r_cnt  <= CW'(W - 1);
                    r_busy <= 1'b1;
                end
            end else begin
                r_q <= r_q << 1;
                if (!r_ovf) begin
                    if (sum > LIMIT) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_acc <= sum[W:0];
                    end
                end
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CW'(1);
                end
            end
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_product     = r_ovf ? {(W-1){1'b1}} : r_acc[W-2:0];
    assign o_overflow    = r_ovf;

endmodule

// ===== rtl/core/integer_gcd_lcm_unit.sv =====
// ----------------------------------------------------------------------------
// Integer GCD/LCM unit
// Greatest common divisor or least common multiple of two signed operands,
// saturated at the largest positive value with an overflow flag.
// ----------------------------------------------------------------------------
// The unit takes one item at a time and is not ready until its result has
// been formed. A divisor item runs the binary GCD loop of shift or subtract
// steps on the shared subtractor, then restores each common factor of two. A
// multiple item then runs the restoring divider and the shift-add multiplier;
// a multiple with a zero operand skips all three engines. A finished result is
// held in the output register until it is taken.
module integer_gcd_lcm_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // operand_a, operand_b
    input  logic [((2 * DATA_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // command
    input  logic                     s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // result
    output logic [((DATA_WIDTH - 1 + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // overflow
    output logic                     m_axis_tuser
);

    localparam int W           = DATA_WIDTH;
    localparam int IN_TDATA_W  = ((2 * W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((W - 1 + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV,
        ST_MUL,
        ST_OUT
    } t_state;

    t_state           r_state;
    gcdl_pkg::t_cmd   r_cmd;
    logic [W-1:0]     r_ma;
    logic [W-1:0]     r_mb;
    logic [W-2:0]     r_value;
    logic             r_ovf;
    logic             r_start_gcd;
    logic             r_start_div;
    logic             r_start_mul;
    logic             r_out_valid;
    logic [W-2:0]     r_out_data;
    logic             r_out_ovf;

    logic [W-1:0]     op_a;
    logic [W-1:0]     op_b;
    logic [W-1:0]     mag_a;
    logic [W-1:0]     mag_b;
    logic             accept;
    logic             out_free;

    gcdl_pkg::t_unit_status gcd_status;
    gcdl_pkg::t_unit_status div_status;
    gcdl_pkg::t_unit_status mul_status;
    logic [W-1:0]     gcd_value;
    logic [W-1:0]     quotient;
    logic [W-2:0]     product;
    logic             product_ovf;

    always_comb begin
        op_a     = s_axis_tdata[W-1:0];
        op_b     = s_axis_tdata[2*W-1:W];
        mag_a    = op_a[W-1] ? (~op_a + W'(1)) : op_a;
        mag_b    = op_b[W-1] ? (~op_b + W'(1)) : op_b;
        accept   = s_axis_tvalid && s_axis_tready;
        out_free = !r_out_valid || m_axis_tready;
    end

    assign s_axis_tready = (r_state == ST_IDLE);

    gcdl_bgcd #(.W(W)) u_bgcd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_start_gcd),
        .i_a      (r_ma),
        .i_b      (r_mb),
        .o_status (gcd_status),
        .o_gcd    (gcd_value)
    );

    gcdl_div #(.W(W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_start_div),
        .i_dividend (r_ma),
        .i_divisor  (gcd_value),
        .o_status   (div_status),
        .o_quotient (quotient)
    );

    gcdl_mul #(.W(W)) u_mul (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_start_mul),
        .i_mplier   (quotient),
        .i_mcand    (r_mb),
        .o_status   (mul_status),
        .o_product  (product),
        .o_overflow (product_ovf)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_start_gcd <= 1'b0;
            r_start_div <= 1'b0;
            r_start_mul <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start_gcd <= 1'b0;
            r_start_div <= 1'b0;
            r_start_mul <= 1'b0;
            if (m_axis_tready && (r_state != ST_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_cmd <= s_axis_tuser;
                        r_ma  <= mag_a;
                        r_mb  <= mag_b;
                        if ((s_axis_tuser == gcdl_pkg::CMD_LCM) &&
                            ((mag_a == '0) || (mag_b == '0))) begin
                            r_value <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= ST_OUT;
                        end else begin
                            r_start_gcd <= 1'b1;
                            r_state     <= ST_GCD;
                        end
                    end
                end
                ST_GCD: begin
                    if (gcd_status.done) begin
                        if (r_cmd == gcdl_pkg::CMD_GCD) begin
                            r_ovf   <= gcd_value[W-1];
                            r_value <= gcd_value[W-1] ? {(W-1){1'b1}} : gcd_value[W-2:0];
                            r_state <= ST_OUT;
                        end else begin
                            r_start_div <= 1'b1;
                            r_state     <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_status.done) begin
                        r_start_mul <= 1'b1;
                        r_state     <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (mul_status.done) begin
                        r_value <= product;
                        r_ovf   <= product_ovf;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_value;
                        r_out_ovf   <= r_ovf;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_data);
    assign m_axis_tuser  = r_out_ovf;

endmodule

// ===== tb/sv/gcd_lcm_checker.sv =====
// ----------------------------------------------------------------------------
// GCD/LCM unit result checker
// Watches both streams of the unit. Every item taken on the input side is
// turned into its expected divisor or multiple, with saturation and overflow,
// and queued. Every item taken on the output side is compared against the
// oldest queued expectation.
// ----------------------------------------------------------------------------
module gcd_lcm_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_tvalid,
    input  logic        i_in_tready,
    // operand_a, operand_b
    input  logic [63:0] i_in_tdata,
    // command
    input  logic        i_in_tuser,
    input  logic        i_out_tvalid,
    input  logic        i_out_tready,
    // result, zero pad bit
    input  logic [31:0] i_out_tdata,
    // overflow
    input  logic        i_out_tuser,
    output int          o_mismatches,
    output int          o_outstanding,
    output int          o_results,
    output int          o_saturated
);

    typedef struct {
        logic [30:0] value;
        logic        overflow;
    } t_gcdl_result;

    localparam longint unsigned SAT_LIMIT = 64'h7FFF_FFFF;

    t_gcdl_result pending_results[$];
    int           mismatches  = 0;
    int           outstanding = 0;
    int           results     = 0;
    int           saturated   = 0;

    assign o_mismatches  = mismatches;
    assign o_outstanding = outstanding;
    assign o_results     = results;
    assign o_saturated   = saturated;

    function automatic longint unsigned operand_magnitude(input logic [31:0] raw);
        logic [31:0] negated;
        negated = ~raw + 32'd1;
        return raw[31] ? longint'(negated) : longint'(raw);
    endfunction

    function automatic longint unsigned euclid_gcd(input longint unsigned x,
                                                   input longint unsigned y);
        longint unsigned r;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    function automatic t_gcdl_result predict_gcd_lcm(input gcdl_pkg::t_cmd cmd,
                                                     input logic [31:0] a,
                                                     input logic [31:0] b);
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned g;
        longint unsigned q;
        longint unsigned value;
        t_gcdl_result    res;
        ma           = operand_magnitude(a);
        mb           = operand_magnitude(b);
        res.overflow = 1'b0;
        if (cmd == gcdl_pkg::CMD_GCD) begin
            value = euclid_gcd(ma, mb);
        end else if (ma == 0 || mb == 0) begin
            value = 0;
        end else begin
            g = euclid_gcd(ma, mb);
            q = ma / g;
            // The bound is tested before forming the product so that nothing wraps.
            if (q > SAT_LIMIT / mb) begin
                value = SAT_LIMIT + 1;
            end else begin
                value = q * mb;
            end
        end
        if (value > SAT_LIMIT) begin
            value        = SAT_LIMIT;
            res.overflow = 1'b1;
        end
        res.value = value[30:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_gcdl_result want;
        if (i_rst_n) begin
            if (i_out_tvalid && i_out_tready) begin
                results++;
                if (i_out_tuser) begin
                    saturated++;
                end
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, %s %0d overflow %0b",
                             $time, "actual value", i_out_tdata, i_out_tuser);
                end else begin
                    want = pending_results.pop_front();
                    if (i_out_tdata != {1'b0, want.value} || i_out_tuser != want.overflow) begin
                        mismatches++;
                        $display("%0t: result mismatch, expected value %0d overflow %0b, %s",
                                 $time, want.value, want.overflow, "actual value");
                        $display("%0t:   actual value %0d overflow %0b",
                                 $time, i_out_tdata, i_out_tuser);
                    end
                end
            end
            if (i_in_tvalid && i_in_tready) begin
                pending_results.push_back(predict_gcd_lcm(gcdl_pkg::t_cmd'(i_in_tuser),
                                                          i_in_tdata[31:0],
                                                          i_in_tdata[63:32]));
            end
            outstanding = pending_results.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// GCD/LCM unit testbench
// Drives operand pairs into the unit with random gaps and random output
// stalls: first corner cases, then random pairs biased toward shared factors,
// powers of two and multiples near the saturation bound. A checker module
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [31:0] MAX_POS  = 32'h7FFF_FFFF;
    localparam logic [31:0] MOST_NEG = 32'h8000_0000;
    localparam int          RANDOM_ITEMS = 700;
    localparam int          HOLD_OFF_CYCLES = 600;
    localparam int          DRAIN_CYCLES = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // operand_a, operand_b
    logic [63:0] s_axis_tdata = '0;
    // command
    logic        s_axis_tuser = gcdl_pkg::CMD_GCD;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // result, zero pad bit
    logic [31:0] m_axis_tdata;
    // overflow
    logic        m_axis_tuser;

    int mismatches;
    int outstanding;
    int results;
    int saturated;
    int gcd_items = 0;
    int lcm_items = 0;
    bit steady = 1'b0;

    logic [31:0] corner_values [9] = '{32'd0, 32'd1, 32'hFFFF_FFFF, MAX_POS, MOST_NEG,
                                       32'h8000_0001, 32'h4000_0000, 32'd46340, 32'd46341};

    always #5 i_clk = ~i_clk;

    integer_gcd_lcm_unit #(
        .DATA_WIDTH(32)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    gcd_lcm_checker checker_inst (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_tvalid(s_axis_tvalid),
        .i_in_tready(s_axis_tready),
        .i_in_tdata(s_axis_tdata),
        .i_in_tuser(s_axis_tuser),
        .i_out_tvalid(m_axis_tvalid),
        .i_out_tready(m_axis_tready),
        .i_out_tdata(m_axis_tdata),
        .i_out_tuser(m_axis_tuser),
        .o_mismatches(mismatches),
        .o_outstanding(outstanding),
        .o_results(results),
        .o_saturated(saturated)
    );

    task automatic offer_pair(input gcdl_pkg::t_cmd cmd, input logic [31:0] a,
                              input logic [31:0] b);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (cmd == gcdl_pkg::CMD_LCM) begin
            lcm_items++;
        end else begin
            gcd_items++;
        end
    endtask

    initial begin
        int          stall;
        int          taken;
        taken = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            // One long hold-off lets the sender back up against a busy unit.
            if (taken == 150) begin
                stall = HOLD_OFF_CYCLES;
            end else begin
                stall = steady ? 0 : $urandom_range(0, 14);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            taken++;
        end
    end

    initial begin
        gcdl_pkg::t_cmd cmd;
        logic [31:0]    a;
        logic [31:0]    b;
        int             kind;
        int             k;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        offer_pair(gcdl_pkg::CMD_GCD, 32'd0, 32'd0);
        offer_pair(gcdl_pkg::CMD_GCD, 32'd0, -32'sd77);
        offer_pair(gcdl_pkg::CMD_GCD, 32'd123456, 32'd0);
        offer_pair(gcdl_pkg::CMD_GCD, MOST_NEG, 32'd0);
        offer_pair(gcdl_pkg::CMD_GCD, MOST_NEG, MOST_NEG);
        offer_pair(gcdl_pkg::CMD_GCD, MAX_POS, MOST_NEG);
        offer_pair(gcdl_pkg::CMD_GCD, -32'sd12, 32'd18);
        offer_pair(gcdl_pkg::CMD_GCD, 32'd1, 32'hFFFF_FFFF);
        offer_pair(gcdl_pkg::CMD_GCD, 32'h4000_0000, 32'h0000_C000);
        offer_pair(gcdl_pkg::CMD_GCD, MAX_POS, MAX_POS);
        offer_pair(gcdl_pkg::CMD_LCM, 32'd0, 32'd55);
        offer_pair(gcdl_pkg::CMD_LCM, MOST_NEG, 32'd0);
        offer_pair(gcdl_pkg::CMD_LCM, 32'd0, 32'd0);
        offer_pair(gcdl_pkg::CMD_LCM, MOST_NEG, 32'd1);
        offer_pair(gcdl_pkg::CMD_LCM, MOST_NEG, MOST_NEG);
        offer_pair(gcdl_pkg::CMD_LCM, MAX_POS, MAX_POS);
        offer_pair(gcdl_pkg::CMD_LCM, MAX_POS, 32'h7FFF_FFFE);
        offer_pair(gcdl_pkg::CMD_LCM, -32'sd4, 32'd6);
        offer_pair(gcdl_pkg::CMD_LCM, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_pair(gcdl_pkg::CMD_LCM, 32'd46341, -32'sd46341);
        offer_pair(gcdl_pkg::CMD_LCM, 32'd65536, 32'd65537);
        offer_pair(gcdl_pkg::CMD_LCM, 32'h4000_0000, 32'd2);
        offer_pair(gcdl_pkg::CMD_LCM, 32'h4000_0000, 32'd3);
        offer_pair(gcdl_pkg::CMD_LCM, 32'd46340, 32'd46341);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 300 && n < 380);
            cmd    = $urandom_range(0, 1) ? gcdl_pkg::CMD_LCM : gcdl_pkg::CMD_GCD;
            kind   = $urandom_range(0, 99);
            if (kind < 25) begin
                a = $urandom();
                b = $urandom();
            end else if (kind < 50) begin
                k = $urandom_range(1, 65535);
                a = k * $urandom_range(0, 32767);
                b = k * $urandom_range(0, 32767);
            end else if (kind < 65) begin
                a = $urandom_range(0, 2000) - 1000;
                b = $urandom_range(0, 2000) - 1000;
            end else if (kind < 80) begin
                a = $urandom_range(1, 255) << $urandom_range(0, 23);
                b = $urandom_range(1, 255) << $urandom_range(0, 23);
            end else if (kind < 90) begin
                a = $urandom_range(30000, 70000);
                b = $urandom_range(30000, 70000);
            end else begin
                a = corner_values[$urandom_range(0, 8)];
                b = $urandom_range(0, 1) ? corner_values[$urandom_range(0, 8)] : $urandom();
            end
            if (kind >= 25 && kind < 90) begin
                a = $urandom_range(0, 1) ? -a : a;
                b = $urandom_range(0, 1) ? -b : b;
            end
            offer_pair(cmd, a, b);
        end
        s_axis_tvalid <= 1'b0;
        steady = 1'b0;

        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d divisor and %0d multiple items, %0d results checked.",
                 gcd_items, lcm_items, results);
        $display("Of those, %0d results saturated with the overflow flag set.", saturated);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Timeout waiting for the unit to finish its items.");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
